/* design/tse_pkg.sv */
`default_nettype none

package tse_pkg;

  // Widths of the payload fields.
  localparam int XW = 24;
  localparam int SW = 64;
  localparam int CW = 7;

  // Q7.16 argument is widened to Q31.32 by this shift.
  localparam int FRAC_SHIFT = 16;

  // Magnitude product is |term| (64 bits) times |x| (24 bits), split in two 32-bit halves.
  localparam int HALF_W = 32;
  localparam int MXW    = XW;
  localparam int LO_W   = HALF_W + MXW;
  localparam int MID_W  = HALF_W + MXW - 1;

  // Divider: dividend is the product shifted right by 16, padded to a whole
  // number of 8-bit digits; one digit is retired per cycle.
  localparam int DIV_DIGIT = 8;
  localparam int DQ_W      = 72;
  localparam int DIV_STEPS = DQ_W / DIV_DIGIT;

  // Reset value of the term count register.
  localparam logic [CW-1:0] TERM_COUNT_RST = 7'd20;

  // Saturation limits of Q31.32.
  localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef logic signed [XW-1:0] x_value_t;
  typedef logic signed [SW-1:0] exp_sum_t;
  typedef logic [CW-1:0]        term_count_t;

endpackage

`default_nettype wire

/* design/tse_in_if.sv */
`default_nettype none

interface tse_in_if;
  logic               valid;
  logic               ready;
  tse_pkg::x_value_t  x_value;

  modport source (output valid, output x_value, input ready);
  modport sink   (input valid, input x_value, output ready);
endinterface

`default_nettype wire

/* design/tse_out_if.sv */
`default_nettype none

interface tse_out_if;
  logic               valid;
  logic               ready;
  tse_pkg::exp_sum_t  exp_sum;
  logic               overflow;

  modport source (output valid, output exp_sum, output overflow, input ready);
  modport sink   (input valid, input exp_sum, input overflow, output ready);
endinterface

`default_nettype wire

/* design/tse_cfg_if.sv */
`default_nettype none

interface tse_cfg_if;
  logic                  valid;
  logic                  ready;
  tse_pkg::term_count_t  term_count;

  modport source (output valid, output term_count, input ready);
  modport sink   (input valid, input term_count, output ready);
endinterface

`default_nettype wire

/* design/taylor_series_exp_core.sv */
// Truncated Taylor series of e^x in fixed point.
// in_ch carries one word per argument x_value (signed Q7.16). out_ch returns one
// word per argument: exp_sum (signed Q31.32, saturated) and overflow, set when any
// term or partial sum saturated. cfg_ch writes term_count, the number of terms
// summed after the constant one; it is always ready. The user is to write it only
// while idle; the block itself does not enforce this. Each term goes through one
// shared 32x24 multiplier (two passes), a carry-save free add that assembles the
// product, a divider that retires one 8-bit quotient digit per cycle, a saturation
// step and an accumulate step; the clamped count sets how many terms each argument
// takes, and a count below two goes straight to the result, one plus x.
// in_ch.ready is high only while no argument is in work.
// A finished result waits in the output register while a new argument may be
// taken; if the receiver stalls, the next result holds until that word is taken.
// Reset (rst_n low, synchronous) drops all work, clears out_ch.valid and sets
// term_count back to 20.
`default_nettype none

module taylor_series_exp_core #(
  parameter int MAX_TERMS = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tse_in_if.sink     in_ch,
  tse_out_if.source  out_ch,
  tse_cfg_if.sink    cfg_ch
);

  // Largest count that can take effect, and the width of the term index.
  localparam int CMAX = (MAX_TERMS < 127) ? MAX_TERMS : 127;
  localparam int NW   = $clog2(CMAX + 2);
  localparam logic [NW-1:0] CNT_LIMIT = NW'(CMAX);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULLO,
    ST_MULHI,
    ST_COMB,
    ST_DIV,
    ST_FIN,
    ST_ACC,
    ST_DONE
  } state_t;

  state_t                              state_r;
  tse_pkg::term_count_t                term_count_r;
  logic                                out_valid_r;
  tse_pkg::exp_sum_t                   out_sum_r;
  logic                                out_ovf_r;

  logic signed [tse_pkg::XW-1:0]       x_r;
  logic [tse_pkg::MXW-1:0]             xm_r;
  logic signed [tse_pkg::SW-1:0]       term_r;
  logic [tse_pkg::SW-1:0]              tm_r;
  logic signed [tse_pkg::SW-1:0]       sum_r;
  logic                                sat_r;
  logic [NW-1:0]                       n_r;
  logic [NW-1:0]                       cnt_r;
  logic [tse_pkg::LO_W-1:0]            lo_r;
  logic [tse_pkg::MID_W-1:0]           mid_r;
  logic                                qbig_r;
  logic [tse_pkg::DQ_W-1:0]            dq_r;
  logic [NW-1:0]                       rem_r;
  logic [$clog2(tse_pkg::DIV_STEPS)-1:0] step_r;

  logic                                in_fire;
  logic [NW-1:0]                       cnt_clamped;
  logic [tse_pkg::MXW-1:0]             x_abs;
  logic signed [tse_pkg::SW-1:0]       x_wide;
  logic [tse_pkg::HALF_W-1:0]          mul_a;
  logic [tse_pkg::LO_W-1:0]            mul_p;
  logic [NW-1:0]                       rem_nxt;
  logic [tse_pkg::DIV_DIGIT-1:0]       qdig_nxt;
  logic [NW:0]                         part;
  logic                                neg;
  logic                                term_ovf;
  logic [tse_pkg::SW-1:0]              mag;
  logic signed [tse_pkg::SW-1:0]       sum_add;
  logic                                sum_ovf;

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.exp_sum  = out_sum_r;
  assign out_ch.overflow = out_ovf_r;

  assign in_fire = in_ch.valid && (state_r == ST_IDLE);

  // Count clamped to the largest supported number of terms.
  always_comb begin
    if (int'(term_count_r) > CMAX) begin
      cnt_clamped = CNT_LIMIT;
    end else begin
      cnt_clamped = NW'(term_count_r);
    end
  end

  // Argument magnitude and its Q31.32 form.
  assign x_abs  = in_ch.x_value[tse_pkg::XW-1] ? tse_pkg::MXW'(-in_ch.x_value)
                                              : tse_pkg::MXW'(in_ch.x_value);
  assign x_wide = tse_pkg::SW'(in_ch.x_value) <<< tse_pkg::FRAC_SHIFT;

  // Shared multiplier: low half of |term| first, then the high half.
  assign mul_a = (state_r == ST_MULHI) ? tm_r[tse_pkg::SW-1:tse_pkg::HALF_W]
                                       : tm_r[tse_pkg::HALF_W-1:0];
  assign mul_p = tse_pkg::LO_W'(mul_a) * tse_pkg::LO_W'(xm_r);

  // One quotient digit of the division by n: eight compare-and-subtract steps.
  always_comb begin
    rem_nxt  = rem_r;
    qdig_nxt = '0;
    part     = '0;
    for (int i = 0; i < tse_pkg::DIV_DIGIT; i++) begin
      part = {rem_nxt, dq_r[tse_pkg::DQ_W-1-i]};
      if (part >= {1'b0, n_r}) begin
        part = part - {1'b0, n_r};
        qdig_nxt[tse_pkg::DIV_DIGIT-1-i] = 1'b1;
      end
      rem_nxt = part[NW-1:0];
    end
  end

  // Sign and range of the new term.
  assign neg      = term_r[tse_pkg::SW-1] ^ x_r[tse_pkg::XW-1];
  assign mag      = dq_r[tse_pkg::SW-1:0];
  assign term_ovf = qbig_r || (|dq_r[tse_pkg::DQ_W-1:tse_pkg::SW]) ||
                    (dq_r[tse_pkg::SW-1] && (!neg || (|dq_r[tse_pkg::SW-2:0])));

  // Saturating accumulate.
  assign sum_add = sum_r + term_r;
  assign sum_ovf = (sum_r[tse_pkg::SW-1] == term_r[tse_pkg::SW-1]) &&
                   (sum_add[tse_pkg::SW-1] != sum_r[tse_pkg::SW-1]);

  // Sequencer, datapath registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      term_count_r <= tse_pkg::TERM_COUNT_RST;
    end else begin
      if (cfg_ch.valid) begin
        term_count_r <= cfg_ch.term_count;
      end
      // A taken word leaves the output register unless a new one is loaded below.
      if (out_ch.ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            x_r    <= in_ch.x_value;
            xm_r   <= x_abs;
            term_r <= x_wide;
            tm_r   <= tse_pkg::SW'(x_abs) << tse_pkg::FRAC_SHIFT;
            sum_r  <= (tse_pkg::SW'(1) << (2 * tse_pkg::FRAC_SHIFT)) + x_wide;
            sat_r  <= 1'b0;
            n_r    <= NW'(2);
            cnt_r  <= cnt_clamped;
            if (cnt_clamped < NW'(2)) begin
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_MULLO;
            end
          end
        end
        ST_MULLO: begin
          lo_r    <= mul_p;
          state_r <= ST_MULHI;
        end
        ST_MULHI: begin
          mid_r   <= tse_pkg::MID_W'(mul_p);
          state_r <= ST_COMB;
        end
        ST_COMB: begin
          // Product shifted right by 16, ready for the division by n.
          dq_r    <= tse_pkg::DQ_W'({mid_r, {tse_pkg::FRAC_SHIFT{1'b0}}}) +
                     tse_pkg::DQ_W'(lo_r[tse_pkg::LO_W-1:tse_pkg::FRAC_SHIFT]);
          // The high partial quotient alone already reaches 2^31.
          qbig_r  <= (9'(mid_r[tse_pkg::MID_W-1:tse_pkg::MID_W-8]) >= 9'(n_r));
          rem_r   <= '0;
          step_r  <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          dq_r   <= {dq_r[tse_pkg::DQ_W-tse_pkg::DIV_DIGIT-1:0], qdig_nxt};
          rem_r  <= rem_nxt;
          step_r <= step_r + 1'b1;
          if (int'(step_r) == tse_pkg::DIV_STEPS - 1) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (term_ovf) begin
            term_r <= neg ? tse_pkg::SUM_MIN : tse_pkg::SUM_MAX;
            tm_r   <= neg ? tse_pkg::SUM_MIN : tse_pkg::SUM_MAX;
            sat_r  <= 1'b1;
          end else begin
            term_r <= neg ? -mag : mag;
            tm_r   <= mag;
          end
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          if (sum_ovf) begin
            sum_r <= sum_r[tse_pkg::SW-1] ? tse_pkg::SUM_MIN : tse_pkg::SUM_MAX;
            sat_r <= 1'b1;
          end else begin
            sum_r <= sum_add;
          end
          if (n_r == cnt_r) begin
            state_r <= ST_DONE;
          end else begin
            n_r     <= n_r + 1'b1;
            state_r <= ST_MULLO;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_sum_r   <= sum_r;
            out_ovf_r   <= sat_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sim/tse_exp_checker.sv */
module tse_exp_checker #(
  parameter int MAX_TERMS = 64
) (
  input  logic clk,
  input  logic rst_n,
  tse_in_if    in_ch,
  tse_out_if   out_ch,
  tse_cfg_if   cfg_ch,
  output int   n_errors,
  output int   pending,
  output int   n_checked,
  output int   n_sat
);
  timeunit 1ns;
  timeprecision 1ps;

  import tse_pkg::*;

  // Printing stops after this many mismatch lines; counting goes on.
  localparam int PRINT_CAP = 40;
  localparam exp_sum_t ONE_Q32 = exp_sum_t'(64'd1 << 32);

  typedef struct {
    exp_sum_t sum;
    logic     ovf;
  } exp_word_t;

  exp_word_t   exp_q[$];
  exp_word_t   want;
  term_count_t count_reg;

  initial begin
    n_errors  = 0;
    pending   = 0;
    n_checked = 0;
    n_sat     = 0;
    count_reg = TERM_COUNT_RST;
  end

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= PRINT_CAP) begin
      $display("%0t ns: exp mismatch: %s", $time, msg);
    end
  endtask

  // Series sum of e^x: each term is the previous one times x over n, truncated
  // toward zero; terms and partial sums clip at the Q31.32 limits.
  function automatic exp_word_t series_exp(input x_value_t x, input term_count_t tc);
    exp_word_t    w;
    exp_sum_t     term;
    exp_sum_t     sum;
    exp_sum_t     s;
    logic [63:0]  tm;
    logic [63:0]  lim;
    logic [23:0]  xm;
    logic [87:0]  prod;
    logic [87:0]  quo;
    logic [87:0]  hi_prod;
    logic [87:0]  hi_quo;
    logic [87:0]  dvs;
    logic         neg;
    logic         ovf;
    int           cnt;
    term = exp_sum_t'(x) <<< FRAC_SHIFT;
    sum  = ONE_Q32 + term;
    ovf  = 1'b0;
    cnt  = (tc > MAX_TERMS) ? MAX_TERMS : int'(tc);
    for (int n = 2; n <= cnt; n++) begin
      neg     = term[63] ^ x[23];
      tm      = term[63] ? (64'd0 - term) : term;
      xm      = x[23] ? (24'd0 - x) : x;
      dvs     = 88'(n) << FRAC_SHIFT;
      prod    = 88'(tm) * 88'(xm);
      quo     = prod / dvs;
      // The upper half of the term is divided first; a quotient of 2^31 or more
      // there clips the term even when the full quotient would just fit.
      hi_prod = 88'(tm[63:32]) * 88'(xm);
      hi_quo  = hi_prod / dvs;
      lim     = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      if (hi_quo >= 88'h8000_0000 || quo > 88'(lim)) begin
        ovf  = 1'b1;
        term = neg ? SUM_MIN : SUM_MAX;
      end else begin
        term = neg ? exp_sum_t'(64'd0 - quo[63:0]) : exp_sum_t'(quo[63:0]);
      end
      s = sum + term;
      if (sum[63] == term[63] && s[63] != sum[63]) begin
        ovf = 1'b1;
        sum = sum[63] ? SUM_MIN : SUM_MAX;
      end else begin
        sum = s;
      end
    end
    w.sum = sum;
    w.ovf = ovf;
    return w;
  endfunction

  // Watch the three channels: predict each argument word with the register as it
  // stood before this edge, then track the register, and compare each result word
  // with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      count_reg = TERM_COUNT_RST;
      exp_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        exp_q.push_back(series_exp(in_ch.x_value, count_reg));
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        count_reg = cfg_ch.term_count;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (exp_q.size() == 0) begin
          report_mismatch($sformatf("result word with nothing expected: exp_sum=%h overflow=%b",
                                    out_ch.exp_sum, out_ch.overflow));
        end else begin
          want = exp_q.pop_front();
          n_checked++;
          if (want.ovf) begin
            n_sat++;
          end
          if (out_ch.exp_sum !== want.sum) begin
            report_mismatch($sformatf("word %0d exp_sum got %h want %h",
                                      n_checked, out_ch.exp_sum, want.sum));
          end
          if (out_ch.overflow !== want.ovf) begin
            report_mismatch($sformatf("word %0d overflow got %b want %b",
                                      n_checked, out_ch.overflow, want.ovf));
          end
        end
      end
    end
    pending = exp_q.size();
  end

endmodule

/* sim/taylor_series_exp_core_tb.sv */
module taylor_series_exp_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tse_pkg::*;

  localparam int ONE_Q16      = 1 << FRAC_SHIFT;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 100;
  localparam int N_PLAN       = 14;

  // Term counts swept in each idle mix; zero and 127 sit outside the usual range.
  localparam int COUNT_PLAN[N_PLAN] = '{1, 2, 3, 4, 5, 6, 8, 9, 0, 11, 20, 33, 64, 127};

  // Arguments sent first at the reset count: zero, the field limits, whole and
  // half units, larger arguments from -20 to 22, one LSB of either sign and
  // alternating bit patterns.
  localparam int CORNER_X[16] = '{
    0, 8388607, -8388608, ONE_Q16, -ONE_Q16, ONE_Q16 / 2, -ONE_Q16 / 2, 2 * ONE_Q16,
    10 * ONE_Q16, 21 * ONE_Q16 + ONE_Q16 / 2, 22 * ONE_Q16, -20 * ONE_Q16, 1, -1,
    'h555555, 'hAAAAAA
  };

  logic clk;
  logic rst_n;
  int   src_idle_pct;
  int   snk_idle_pct;
  int   n_errors;
  int   pending;
  int   n_checked;
  int   n_sat;
  int   stall_cycles;
  int   n_settings;

  tse_in_if  in_ch ();
  tse_out_if out_ch ();
  tse_cfg_if cfg_ch ();

  taylor_series_exp_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tse_exp_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .n_errors  (n_errors),
    .pending   (pending),
    .n_checked (n_checked),
    .n_sat     (n_sat)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Result side: ready drops at random in the current share of cycles.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog: ends the run when no word moves on any channel for too long.
  initial stall_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timed out with %0d results outstanding.", pending);
      $display("taylor_series_exp_core_tb: FAIL");
      $finish;
    end
  end

  function automatic x_value_t pick_x();
    int sel;
    int span;
    int v;
    sel = $urandom_range(9);
    if (sel < 4) begin
      return x_value_t'($urandom);
    end
    // Four in ten arguments stay within eight units of zero, where the series converges within the count.
    span = (sel < 8) ? 8 * ONE_Q16 : 48 * ONE_Q16;
    v = int'($urandom_range(2 * span)) - span;
    return x_value_t'(v);
  endfunction

  // Send one argument word, with random idle cycles before it.
  task automatic push_x(input x_value_t x);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.x_value <= x;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
  endtask

  // Lower valid and wait until every expected result word has come back.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic write_term_count(input term_count_t v);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.term_count <= v;
    @(posedge clk);
    while (!cfg_ch.ready) begin
      @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
    n_settings++;
  endtask

  task automatic run_phase(input int count);
    int n_words;
    n_words = (count >= 40) ? 5 : ((count >= 16) ? 20 : 60);
    write_term_count(term_count_t'(count));
    repeat (n_words) begin
      push_x(pick_x());
    end
    wait_idle();
  endtask

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.x_value     <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.term_count <= '0;
    rst_n             <= 1'b0;
    src_idle_pct = 23;
    snk_idle_pct = 71;
    n_settings   = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed arguments at the reset count.
    foreach (CORNER_X[i]) begin
      push_x(x_value_t'(CORNER_X[i]));
    end
    wait_idle();

    // A count of zero gives just one plus x.
    write_term_count(term_count_t'(0));
    push_x(x_value_t'(0));
    push_x(x_value_t'(8388607));
    push_x(x_value_t'(-8388608));
    wait_idle();

    // A count above the maximum is clamped; large negative arguments clip the
    // partial sums, which later come back inside the range.
    write_term_count(term_count_t'(127));
    push_x(x_value_t'(8388607));
    push_x(x_value_t'(-8388608));
    push_x(x_value_t'(-30 * ONE_Q16));
    push_x(x_value_t'(-50 * ONE_Q16));
    wait_idle();

    // Random arguments over the count sweep in three idle mixes.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          src_idle_pct = 23;
          snk_idle_pct = 71;
        end
        1: begin
          src_idle_pct = 71;
          snk_idle_pct = 23;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      foreach (COUNT_PLAN[i]) begin
        run_phase(COUNT_PLAN[i]);
      end
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d result words, %0d of them saturated, over %0d term count settings.",
             n_checked, n_sat, n_settings);
    $display("Counts ran from 0 to 127 under sender-heavy, receiver-heavy and no idling.");
    if (n_errors == 0) begin
      $display("taylor_series_exp_core_tb: PASS");
    end else begin
      $display("%0d mismatches.", n_errors);
      $display("taylor_series_exp_core_tb: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
design/tse_pkg.sv
design/tse_in_if.sv
design/tse_out_if.sv
design/tse_cfg_if.sv
design/taylor_series_exp_core.sv
sim/tse_exp_checker.sv
sim/taylor_series_exp_core_tb.sv
